// ----- hw/rtl/rtre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtre_pkg: shared types and constants of the RGB target ramp engine
// Holds the channel payload structs, the controller states, the command and
// status groups between controller and datapath, and the fixed widths.
// ----------------------------------------------------------------------------
package rtre_pkg;

    localparam int PIXEL_COUNT_DEF = 32;
    localparam int PIX_FIELD_W     = 6;
    localparam int COLOR_W         = 8;
    localparam int GAIN_W          = 10;
    localparam int GAIN_FULL       = 1000;
    localparam int GAIN_RESET      = 20;

    // Magnitude of error times gain: 8 bits by 10 bits.
    localparam int MAG_W           = COLOR_W + GAIN_W;

    // Division by GAIN_FULL as a multiplication by a rounded-up reciprocal.
    // Exact for every magnitude up to 255 * 1000.
    localparam int RECIP_SHIFT     = 28;
    localparam int RECIP_MULT      = ((2 ** RECIP_SHIFT) + GAIN_FULL - 1) / GAIN_FULL;
    localparam int RECIP_W         = 19;
    localparam int RECIP_PROD_W    = MAG_W + RECIP_W;

    typedef logic [2:0][COLOR_W-1:0] rgb_t;

    typedef struct packed {
        logic                   action;
        logic [PIX_FIELD_W-1:0] pixel_index;
        logic [COLOR_W-1:0]     red_target;
        logic [COLOR_W-1:0]     green_target;
        logic [COLOR_W-1:0]     blue_target;
    } in_item_t;

    typedef struct packed {
        logic [PIX_FIELD_W-1:0] out_pixel;
        logic [COLOR_W-1:0]     red_now;
        logic [COLOR_W-1:0]     green_now;
        logic [COLOR_W-1:0]     blue_now;
        logic                   frame_end;
    } out_item_t;

    localparam logic ACT_SET_TARGET = 1'b0;
    localparam logic ACT_FRAME_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_DIV,
        ST_WB
    } ctrl_state_t;

    typedef struct packed {
        logic tgt_wr;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic mul_en;
        logic div_en;
        logic wb_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hw/rtl/rtre_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtre_ctrl: sequencer of the RGB target ramp engine
// Accepts items while idle and steps each pixel of a frame tick through
// read, multiply, divide and write-back.
// ----------------------------------------------------------------------------
module rtre_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_action,
    output logic                  s_ready,
    input  rtre_pkg::dp_status_t  status,
    output rtre_pkg::ctrl_cmd_t   cmd
);

    rtre_pkg::ctrl_state_t state_reg;
    rtre_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rtre_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rtre_pkg::ST_IDLE: begin
                if (s_valid && (s_action == rtre_pkg::ACT_FRAME_TICK)) begin
                    state_next = rtre_pkg::ST_READ;
                end
            end
            rtre_pkg::ST_READ: state_next = rtre_pkg::ST_MUL;
            rtre_pkg::ST_MUL:  state_next = rtre_pkg::ST_DIV;
            rtre_pkg::ST_DIV:  state_next = rtre_pkg::ST_WB;
            rtre_pkg::ST_WB: begin
                if (status.out_free) begin
                    state_next = status.last_pixel ? rtre_pkg::ST_IDLE : rtre_pkg::ST_READ;
                end
            end
            default: state_next = rtre_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rtre_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.tgt_wr  = s_valid && (s_action == rtre_pkg::ACT_SET_TARGET);
                cmd.idx_clr = s_valid && (s_action == rtre_pkg::ACT_FRAME_TICK);
            end
            rtre_pkg::ST_READ: cmd.rd_en  = 1'b1;
            rtre_pkg::ST_MUL:  cmd.mul_en = 1'b1;
            rtre_pkg::ST_DIV:  cmd.div_en = 1'b1;
            rtre_pkg::ST_WB: begin
                cmd.wb_en   = status.out_free;
                cmd.idx_inc = status.out_free && !status.last_pixel;
            end
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rtre_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtre_datapath: color stores and ramp arithmetic
// Holds both color memories with their valid bits, the gain register, the
// per-pixel arithmetic stages and the output register.
// ----------------------------------------------------------------------------
module rtre_datapath #(
    parameter int PIXEL_COUNT = rtre_pkg::PIXEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rtre_pkg::GAIN_W-1:0]   cfg_wdata,
    input  rtre_pkg::in_item_t            s_data,
    input  logic                          m_ready,
    output logic                          m_valid,
    output rtre_pkg::out_item_t           m_data,
    input  rtre_pkg::ctrl_cmd_t           cmd,
    output rtre_pkg::dp_status_t          status
);

    localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

    // Stores, valid bits and gain.
    rtre_pkg::rgb_t                 cur_mem_reg [PIXEL_COUNT];
    rtre_pkg::rgb_t                 tgt_mem_reg [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0]         cur_valid_reg;
    logic [PIXEL_COUNT-1:0]         tgt_valid_reg;
    logic [rtre_pkg::GAIN_W-1:0]    gain_reg;
    logic [IDX_W-1:0]               idx_reg;

    // Read stage.
    rtre_pkg::rgb_t                 cur_rd_reg;
    rtre_pkg::rgb_t                 tgt_rd_reg;
    logic                           cur_vld_reg;
    logic                           tgt_vld_reg;

    // Multiply and divide stages.
    rtre_pkg::rgb_t                 base_reg;
    logic [2:0]                     neg_reg;
    logic [2:0][rtre_pkg::MAG_W-1:0] mag_reg;
    rtre_pkg::rgb_t                 quot_reg;

    // Output register.
    logic                           out_valid_reg;
    rtre_pkg::out_item_t            out_data_reg;

    logic                           tgt_in_range;
    logic [rtre_pkg::GAIN_W-1:0]    gain_eff;
    rtre_pkg::rgb_t                 cur_eff;
    rtre_pkg::rgb_t                 tgt_eff;
    logic [2:0]                     neg_next;
    logic [2:0][rtre_pkg::MAG_W-1:0] mag_next;
    rtre_pkg::rgb_t                 quot_next;
    rtre_pkg::rgb_t                 color_next;
    rtre_pkg::rgb_t                 tgt_wdata;

    assign tgt_in_range = ({1'b0, s_data.pixel_index} < 7'(PIXEL_COUNT));
    assign tgt_wdata    = {s_data.red_target, s_data.green_target, s_data.blue_target};
    assign gain_eff     = (gain_reg > rtre_pkg::GAIN_W'(rtre_pkg::GAIN_FULL))
                          ? rtre_pkg::GAIN_W'(rtre_pkg::GAIN_FULL) : gain_reg;

    assign status.last_pixel = (idx_reg == LAST_IDX);
    assign status.out_free   = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg      <= rtre_pkg::GAIN_W'(rtre_pkg::GAIN_RESET);
            cur_valid_reg <= '0;
            tgt_valid_reg <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_wdata;
            end
            if (cmd.tgt_wr && tgt_in_range) begin
                tgt_valid_reg[s_data.pixel_index[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.wb_en) begin
                cur_valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.wb_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Memory writes and registered reads.
    always_ff @(posedge aclk) begin
        if (cmd.tgt_wr && tgt_in_range) begin
            tgt_mem_reg[s_data.pixel_index[IDX_W-1:0]] <= tgt_wdata;
        end
        if (cmd.wb_en) begin
            cur_mem_reg[idx_reg] <= color_next;
        end
        if (cmd.rd_en) begin
            cur_rd_reg  <= cur_mem_reg[idx_reg];
            tgt_rd_reg  <= tgt_mem_reg[idx_reg];
            cur_vld_reg <= cur_valid_reg[idx_reg];
            tgt_vld_reg <= tgt_valid_reg[idx_reg];
        end
    end

    // An entry never written reads as black.
    assign cur_eff = cur_vld_reg ? cur_rd_reg : '0;
    assign tgt_eff = tgt_vld_reg ? tgt_rd_reg : '0;

    always_comb begin
        logic [rtre_pkg::COLOR_W-1:0]           diff;
        logic [rtre_pkg::RECIP_PROD_W-1:0]      recip_prod;
        logic [rtre_pkg::COLOR_W-1:0]           step;
        for (int c = 0; c < 3; c++) begin
            neg_next[c] = (cur_eff[c] < tgt_eff[c]);
            diff        = neg_next[c] ? (tgt_eff[c] - cur_eff[c]) : (cur_eff[c] - tgt_eff[c]);
            mag_next[c] = rtre_pkg::MAG_W'(diff) * rtre_pkg::MAG_W'(gain_eff);

            recip_prod   = rtre_pkg::RECIP_PROD_W'(mag_reg[c])
                           * rtre_pkg::RECIP_PROD_W'(rtre_pkg::RECIP_MULT);
            quot_next[c] = recip_prod[rtre_pkg::RECIP_SHIFT +: rtre_pkg::COLOR_W];

            // A nonzero product whose quotient truncates to zero still moves one count.
            step = ((quot_reg[c] == '0) && (mag_reg[c] != '0))
                   ? rtre_pkg::COLOR_W'(1) : quot_reg[c];
            color_next[c] = neg_reg[c] ? (base_reg[c] + step) : (base_reg[c] - step);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            base_reg <= cur_eff;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
        end
        if (cmd.div_en) begin
            quot_reg <= quot_next;
        end
        if (cmd.wb_en) begin
            out_data_reg.out_pixel <= rtre_pkg::PIX_FIELD_W'(idx_reg);
            out_data_reg.red_now   <= color_next[2];
            out_data_reg.green_now <= color_next[1];
            out_data_reg.blue_now  <= color_next[0];
            out_data_reg.frame_end <= status.last_pixel;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- hw/rtl/rgb_target_ramp_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_target_ramp_engine_unit: RGB target ramp engine, top level
// Fades a table of pixels toward their target colors, a fraction of the
// remaining error per frame tick, and streams out every updated pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                       Direction  Moves
//  input     s_valid / s_ready / s_data  in         target write or frame tick
//  result    m_valid / m_ready / m_data  out        one updated pixel color
//  config    cfg_we / cfg_wdata          in         ramp gain, thousandths
//
// A target write produces no result. A frame tick walks the pixels one by
// one, and the block takes no new input transfer meanwhile: each pixel
// runs in turn through a memory read, the error times gain multiply, the
// reciprocal multiply that divides by one thousand, and write-back into the
// current-color store.
// Reset is synchronous and active low; both stores read as black afterward
// through per-entry valid bits, so no clearing pass is needed.
// A stalled result holds write-back of the next pixel; the block takes a new
// input transfer once the last pixel of a frame sits in the output register.
// ----------------------------------------------------------------------------
module rgb_target_ramp_engine_unit #(
    parameter int PIXEL_COUNT = rtre_pkg::PIXEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rtre_pkg::GAIN_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rtre_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rtre_pkg::out_item_t           m_data
);

    // The controller sees only the handshake and the action bit of the input;
    // all arithmetic and storage live in the datapath.
    rtre_pkg::ctrl_cmd_t  cmd;
    rtre_pkg::dp_status_t status;

    rtre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_data.action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rtre_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hw/rtl/rtre_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtre_checker: port-level assertions for the RGB target ramp engine
// Watches the top-level ports and flags sequencing slips over time.
// ----------------------------------------------------------------------------
module rtre_checker #(
    parameter int PIXEL_COUNT = rtre_pkg::PIXEL_COUNT_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input rtre_pkg::in_item_t   s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input rtre_pkg::out_item_t  m_data
);

    // A stalled result transfer holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result payload changed while stalled");

    // A frame tick closes the input side until the frame is walked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.action == rtre_pkg::ACT_FRAME_TICK)) |=> !s_ready)
        else $error("input accepted right after a frame tick");

    // While a pending result is not the last of its frame, the input side stays closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_end) |-> !s_ready)
        else $error("input ready while a frame is still being walked");

    // Reported pixel indexes stay inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.out_pixel} < 7'(PIXEL_COUNT)))
        else $error("pixel index beyond table");

endmodule

bind rgb_target_ramp_engine_unit rtre_checker #(
    .PIXEL_COUNT (PIXEL_COUNT)
) u_rtre_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
